// File: rtl/qcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qcf_pkg
// Shared types and codes for the quantum-charging process queue.
// ----------------------------------------------------------------------------
package qcf_pkg;

	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int LIM_W  = 6;
	localparam int OCC_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCIPLINE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_LIMIT  = 2'd2;

	// reset values of the configuration registers
	localparam logic [TIME_W-1:0] QUANTUM_RST = 16'd8;
	localparam logic [LIM_W-1:0]  CAP_LIMIT_RST = 6'd32;

	typedef enum logic {
		DISC_RR   = 1'b0,
		DISC_FCFS = 1'b1
	} discipline_t;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] remaining;
	} entry_t;

endpackage
`default_nettype wire

// File: rtl/quantum_charging_fifo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quantum_charging_fifo_core
// Bounded FIFO of process entries (id, remaining burst) with burst charging.
// ----------------------------------------------------------------------------
// Result: done strobes in the cycle after its transaction
//   is taken (start high, busy low).
// Throughput: one transaction every cycle; the single-port entry memory is
//   written by an enqueue or read by a dequeue, never both in one cycle.
// busy never rises and the receiver cannot stall the result.
// Reset (arst_n low): pointers and count clear, registers take their reset
//   values; the entry memory is not cleared.
module quantum_charging_fifo_core import qcf_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// command side
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              mode,
	input  wire logic [ID_W-1:0]   proc_id,
	input  wire logic [TIME_W-1:0] burst_ms,
	// result side
	output logic                   done,
	output logic                   accepted,
	output logic [ID_W-1:0]        out_id,
	output logic [TIME_W-1:0]      out_remaining_ms,
	output logic                   now_empty,
	output logic [OCC_W-1:0]       occupancy
);

	// pointer and count widths follow the depth
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	// common width for comparing the count against the configured limit
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// configuration registers
	logic [TIME_W-1:0] quantum_q;
	discipline_t       discipline_q;
	logic [LIM_W-1:0]  cap_limit_q;

	// queue control state
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	// entry memory, one synchronous port
	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_data_s1;

	// result stage
	logic             done_s1;
	logic             ok_s1;
	logic             deq_s1;

	logic             take;
	logic             is_deq;
	logic             full;
	logic             limit_used;
	logic [CMP_W-1:0] count_cmp;
	logic [CMP_W-1:0] limit_cmp;
	logic             enq_ok;
	logic             deq_ok;
	logic [TIME_W-1:0] charged;
	logic [PTR_W-1:0] rd_ptr_nxt;
	logic [PTR_W-1:0] wr_ptr_nxt;

	// The queue answers every cycle, so never hold the command side off.
	assign busy   = 1'b0;
	assign take   = start && !busy;
	assign is_deq = (mode_t'(mode) == MODE_DEQ);

	// Effective limit: zero or anything above the depth acts as the depth.
	always_comb begin
		count_cmp  = CMP_W'(count_q);
		limit_cmp  = CMP_W'(cap_limit_q);
		limit_used = (cap_limit_q != '0) && (limit_cmp <= DEPTH_CMP);
		full       = (count_cmp >= DEPTH_CMP) || (limit_used && (count_cmp >= limit_cmp));
	end

	assign enq_ok = take && !is_deq && !full;
	assign deq_ok = take && is_deq && (count_q != '0);

	// Charge the burst: round robin drops one quantum clamped at zero,
	// first come first served drops the lot.
	always_comb begin
		unique case (discipline_q)
			DISC_FCFS: charged = '0;
			DISC_RR:   charged = (burst_ms > quantum_q) ? (burst_ms - quantum_q) : '0;
			default:   charged = '0;
		endcase
	end

	// Advance pointers with wrap at the last slot.
	assign rd_ptr_nxt = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_ONE;
	assign wr_ptr_nxt = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_ONE;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RST;
			discipline_q <= DISC_RR;
			cap_limit_q  <= CAP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUANTUM:    quantum_q    <= cfg_wdata;
				REG_DISCIPLINE: discipline_q <= discipline_t'(cfg_wdata[0]);
				REG_CAP_LIMIT:  cap_limit_q  <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Pointers and count: only one of enqueue and dequeue per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else if (enq_ok) begin
			wr_ptr_q <= wr_ptr_nxt;
			count_q  <= count_q + CNT_ONE;
		end else if (deq_ok) begin
			rd_ptr_q <= rd_ptr_nxt;
			count_q  <= count_q - CNT_ONE;
		end
	end

	// Entry memory: write the charged entry, or read the oldest one.
	// A dequeue of a slot always comes in a later transaction than the
	// enqueue that wrote it, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (enq_ok) begin
			mem_q[wr_ptr_q] <= '{id: proc_id, remaining: charged};
		end
		if (deq_ok) begin
			rd_data_s1 <= mem_q[rd_ptr_q];
		end
	end

	// Result stage: one strobe per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			ok_s1   <= 1'b0;
			deq_s1  <= 1'b0;
		end else begin
			done_s1 <= take;
			ok_s1   <= enq_ok || deq_ok;
			deq_s1  <= deq_ok;
		end
	end

	// The count register already holds the post-transaction value while the
	// result is shown; the next transaction updates it at the end of that cycle.
	assign done             = done_s1;
	assign accepted         = ok_s1;
	assign out_id           = deq_s1 ? rd_data_s1.id : '0;
	assign out_remaining_ms = deq_s1 ? rd_data_s1.remaining : '0;
	assign now_empty        = (count_q == '0);
	assign occupancy        = OCC_W'(count_q);

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= DEPTH_CMP)
		else $error("entry count above queue depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("transaction without result strobe");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |-> count_q != '0 && !enq_ok)
		else $error("dequeue from empty queue or mixed transaction");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> count_q == $past(count_q))
		else $error("refused transaction changed the count");

endmodule
`default_nettype wire

// File: tb/quantum_charging_fifo_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quantum_charging_fifo_core_tb
// Self-checking bench for the burst-charging process queue. A behavioural
// queue model predicts every result. A checker compares each strobed result
// with the oldest prediction. Directed cases cover the charge rules, the
// capacity rules and the empty queue. Randomised fill and drain traffic then
// runs under several register settings, with random sender gaps.
// ----------------------------------------------------------------------------
module quantum_charging_fifo_core_tb import qcf_pkg::*; ();

	localparam int DEPTH = 32;
	// index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// how many edges to wait for outstanding results before giving up
	localparam int DRAIN_GUARD = 100;

	typedef struct packed {
		logic              accepted;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] remaining;
		logic              now_empty;
		logic [OCC_W-1:0]  occupancy;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	logic                  busy;
	logic                  mode;
	logic [ID_W-1:0]       proc_id;
	logic [TIME_W-1:0]     burst_ms;
	logic                  done;
	logic                  accepted;
	logic [ID_W-1:0]       out_id;
	logic [TIME_W-1:0]     out_remaining_ms;
	logic                  now_empty;
	logic [OCC_W-1:0]      occupancy;

	// model copy of the registers and of the queue contents
	logic [TIME_W-1:0] cfg_quantum;
	discipline_t       cfg_discipline;
	logic [LIM_W-1:0]  cfg_limit;
	entry_t            queued_entries[$];
	// predicted results, oldest first
	result_t           pending_results[$];

	int unsigned errors;
	int unsigned n_stored, n_refused, n_popped, n_empty_pops, n_checked, n_cfg_writes;

	quantum_charging_fifo_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.proc_id          (proc_id),
		.burst_ms         (burst_ms),
		.done             (done),
		.accepted         (accepted),
		.out_id           (out_id),
		.out_remaining_ms (out_remaining_ms),
		.now_empty        (now_empty),
		.occupancy        (occupancy)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Queue model
	// ------------------------------------------------------------------

	// A limit of zero, or one beyond the storage, falls back to the depth.
	function automatic int unsigned effective_limit();
		if (cfg_limit == '0 || cfg_limit > DEPTH) return DEPTH;
		return cfg_limit;
	endfunction

	// Charge the burst on its way in: full charge leaves nothing, a round
	// robin slice comes off and clamps at zero.
	function automatic logic [TIME_W-1:0] charged_burst(input logic [TIME_W-1:0] burst);
		if (cfg_discipline == DISC_FCFS) return '0;
		if (burst <= cfg_quantum) return '0;
		return burst - cfg_quantum;
	endfunction

	// Apply one taken transaction to the model and queue up its result.
	task automatic predict_result(input mode_t op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] burst);
		result_t r;
		entry_t  e;
		r = '0;
		if (op == MODE_ENQ) begin
			if (queued_entries.size() < effective_limit()) begin
				e.id        = id;
				e.remaining = charged_burst(burst);
				queued_entries.push_back(e);
				r.accepted = 1'b1;
				n_stored++;
			end else begin
				n_refused++;
			end
		end else begin
			if (queued_entries.size() != 0) begin
				e           = queued_entries.pop_front();
				r.accepted  = 1'b1;
				r.id        = e.id;
				r.remaining = e.remaining;
				n_popped++;
			end else begin
				n_empty_pops++;
			end
		end
		r.now_empty = (queued_entries.size() == 0);
		r.occupancy = OCC_W'(queued_entries.size());
		pending_results.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Result checker: the receiver cannot stall, so sample on every edge
	// at which done was high during the cycle just ended.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: stray result, expected none, actual accepted=%0d id=%0d",
					$time, accepted, out_id);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				check_field("accepted", want.accepted, accepted);
				check_field("out_id", want.id, out_id);
				check_field("out_remaining_ms", want.remaining, out_remaining_ms);
				check_field("now_empty", want.now_empty, now_empty);
				check_field("occupancy", want.occupancy, occupancy);
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks. Every task returns just after a rising edge, so all
	// drives below land as nonblocking updates at that edge.
	// ------------------------------------------------------------------

	// Send one transaction after an optional gap. Leave start high on the
	// way out so that a gapless follower keeps it high without a glitch.
	task automatic send_op(input mode_t op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] burst, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		mode     <= op;
		proc_id  <= id;
		burst_ms <= burst;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_result(op, id, burst);
	endtask

	// Drop start and hold until every predicted result has been checked,
	// then wait out a settling margin.
	task automatic wait_drained();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: results still outstanding, expected 0, actual %0d", $time,
				pending_results.size());
			errors++;
		end
		repeat (3) @(posedge clk);
	endtask

	// Write one register; only ever called with the queue drained. Leave the
	// enable high so back-to-back writes need no extra drive; the caller drops it.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		n_cfg_writes++;
		case (idx)
			REG_QUANTUM:    cfg_quantum = data;
			REG_DISCIPLINE: cfg_discipline = discipline_t'(data[0]);
			REG_CAP_LIMIT:  cfg_limit = data[LIM_W-1:0];
			default: ;
		endcase
	endtask

	// Write all three registers; spare upper data bits get random junk now
	// and then, since only the low bits of the narrow registers count.
	task automatic set_config(input logic [TIME_W-1:0] q, input discipline_t disc,
			input logic [LIM_W-1:0] lim);
		logic [CFG_DATA_W-1:0] junk;
		wait_drained();
		junk = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom_range(0, 65535)) : '0;
		cfg_write(REG_QUANTUM, q);
		cfg_write(REG_DISCIPLINE, {junk[CFG_DATA_W-1:1], disc});
		cfg_write(REG_CAP_LIMIT, {junk[CFG_DATA_W-1:LIM_W], lim});
		cfg_we <= 1'b0;
	endtask

	// Bursts bunch around the current quantum, the range ends and small values, or fall anywhere.
	function automatic logic [TIME_W-1:0] random_burst();
		int v;
		case ($urandom_range(0, 3))
			0: return TIME_W'($urandom_range(0, 65535));
			1: begin
				v = int'(cfg_quantum) + int'($urandom_range(0, 6)) - 3;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				return TIME_W'(v);
			end
			2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return TIME_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Random traffic in runs that lean towards filling, draining or mixing,
	// so the queue keeps hitting both full and empty. Some runs are gapless.
	task automatic random_traffic(input int unsigned n_items);
		int unsigned left, run_len, enq_pct, gap, i;
		bit          gappy;
		mode_t       op;
		left = n_items;
		while (left > 0) begin
			run_len = $urandom_range(10, 45);
			if (run_len > left) run_len = left;
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			gappy = ($urandom_range(0, 2) != 0);
			for (i = 0; i < run_len; i++) begin
				op  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
				gap = gappy ? $urandom_range(0, 13) : 0;
				send_op(op, ID_W'($urandom_range(0, 255)), random_burst(), gap);
			end
			left -= run_len;
		end
	endtask

	// ------------------------------------------------------------------
	// Test cases
	// ------------------------------------------------------------------

	// Pop straight after reset: nothing to return.
	task automatic test_empty_dequeue();
		send_op(MODE_DEQ, 8'hFF, 16'hFFFF, 0);
	endtask

	// Reset quantum of 8: zero, equal, one above and top bursts, then pop.
	task automatic test_round_robin_charge();
		send_op(MODE_ENQ, 8'h00, 16'd0, 0);
		send_op(MODE_ENQ, 8'hFF, 16'd8, 0);
		send_op(MODE_ENQ, 8'hA5, 16'd9, 0);
		send_op(MODE_ENQ, 8'h5A, 16'hFFFF, 0);
		repeat (4) send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
	endtask

	// Zero quantum passes bursts through; the top quantum swallows them.
	task automatic test_quantum_extremes();
		set_config(16'd0, DISC_RR, 6'd32);
		send_op(MODE_ENQ, 8'h11, 16'hFFFF, 0);
		send_op(MODE_ENQ, 8'h22, 16'd1, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
		set_config(16'hFFFF, DISC_RR, 6'd32);
		send_op(MODE_ENQ, 8'h33, 16'hFFFF, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
	endtask

	// First come first served charges the whole burst.
	task automatic test_full_charge();
		set_config(16'd8, DISC_FCFS, 6'd32);
		send_op(MODE_ENQ, 8'h77, 16'hFFFF, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
	endtask

	// Limit of one: second push refused, then pop to empty and past it.
	task automatic test_capacity_limit();
		set_config(16'd8, DISC_RR, 6'd1);
		send_op(MODE_ENQ, 8'h01, 16'd100, 0);
		send_op(MODE_ENQ, 8'h02, 16'd200, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
	endtask

	// A write to the unused index must leave all settings alone.
	task automatic test_unused_index();
		wait_drained();
		cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		send_op(MODE_ENQ, 8'h44, 16'd300, 0);
		send_op(MODE_ENQ, 8'h45, 16'd301, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
		send_op(MODE_DEQ, 8'h00, 16'h0000, 0);
	endtask

	// Random traffic across settings, extremes included. Limits of zero and
	// above the depth both act as the full depth; the pointers wrap often.
	task automatic test_random_settings();
		set_config(16'd8, DISC_RR, 6'd32);
		random_traffic(150);
		set_config(16'd0, DISC_RR, 6'd0);
		random_traffic(150);
		set_config(16'hFFFF, DISC_RR, 6'd63);
		random_traffic(150);
		set_config(TIME_W'($urandom_range(0, 65535)), DISC_RR, 6'd1);
		random_traffic(100);
		set_config(TIME_W'($urandom_range(0, 200)), DISC_FCFS, 6'd33);
		random_traffic(150);
		set_config(TIME_W'($urandom_range(1, 300)), DISC_RR, LIM_W'($urandom_range(2, 31)));
		random_traffic(150);
		set_config(16'd1, DISC_FCFS, 6'd32);
		random_traffic(100);
		set_config(TIME_W'($urandom_range(0, 65535)), discipline_t'($urandom_range(0, 1)),
			LIM_W'($urandom_range(0, 63)));
		random_traffic(150);
	endtask

	// Hold the sender mid-stream until every result is back, then resume.
	task automatic test_sender_pause();
		set_config(TIME_W'($urandom_range(0, 64)), DISC_RR, 6'd32);
		random_traffic(50);
		wait_drained();
		random_traffic(50);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		// Hold every input at a known value from time zero.
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		start          = 1'b0;
		mode           = MODE_ENQ;
		proc_id        = '0;
		burst_ms       = '0;
		cfg_quantum    = QUANTUM_RST;
		cfg_discipline = DISC_RR;
		cfg_limit      = CAP_LIMIT_RST;
		errors         = 0;
		n_stored       = 0;
		n_refused      = 0;
		n_popped       = 0;
		n_empty_pops   = 0;
		n_checked      = 0;
		n_cfg_writes   = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dequeue();
		test_round_robin_charge();
		test_quantum_extremes();
		test_full_charge();
		test_capacity_limit();
		test_unused_index();
		test_random_settings();
		test_sender_pause();

		// Drain the tail and give the block its latency before judging.
		wait_drained();

		$display("Run covered %0d transactions: %0d stored, %0d refused,",
			n_stored + n_refused + n_popped + n_empty_pops, n_stored, n_refused);
		$display("%0d pops returned, %0d on empty queue, %0d checked, %0d writes, %0d errors.",
			n_popped, n_empty_pops, n_checked, n_cfg_writes, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Timeout: stimulus or results did not complete.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
